[rtl/rrps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rrps_pkg
// Shared types and constants of the round-robin process scheduler.
// ============================================================================
package rrps_pkg;

    // ready queue geometry
    localparam int QUEUE_DEPTH = 64;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // process id and counter widths
    localparam int ID_WIDTH = 16;
    localparam int RUN_W    = 32;
    localparam int TOTAL_W  = 48;
    localparam int ENTRY_W  = ID_WIDTH + RUN_W;

    // configuration registers
    localparam int SLICE_W   = 16;
    localparam int TICK_W    = 32;
    localparam int QLIMIT_W  = 7;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int LIM_W      = (QCNT_W > QLIMIT_W) ? QCNT_W : QLIMIT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT  = 2'd2;

    localparam logic [SLICE_W-1:0]  SLICE_LENGTH_RST = 16'd1000;
    localparam logic [TICK_W-1:0]   TICK_LIMIT_RST   = 32'd50000;
    localparam logic [QLIMIT_W-1:0] QUEUE_LIMIT_RST  = 7'd64;

    typedef struct packed {
        logic arrival;
        logic terminate;
    } req_t;

    typedef struct packed {
        logic [15:0]        running_id;
        logic               running_idle;
        logic [TOTAL_W-1:0] total_run;
        logic               arrival_dropped;
        logic               finished;
    } res_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic count;
        logic rotate;
        logic arrive;
        logic term;
        logic take;
        logic result;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic done;
        logic slice_end;
        logic nonempty;
        logic term_take;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

[rtl/rrps_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rrps_ctrl
// Tick sequencer: walks one request through count, rotate, arrival,
// terminate, take and result steps.
// ============================================================================
module rrps_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire rrps_pkg::status_t status,
    output rrps_pkg::cmd_t         cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_COUNT  = 7'b0000010,
        ST_ROT    = 7'b0000100,
        ST_ARRIVE = 7'b0001000,
        ST_TERM   = 7'b0010000,
        ST_TAKE   = 7'b0100000,
        ST_RESULT = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                cmd.count = 1'b1;
                if (status.done)
                    state_next = ST_RESULT;
                else if (status.slice_end && status.nonempty)
                    state_next = ST_ROT;
                else
                    state_next = ST_ARRIVE;
            end
            ST_ROT:
            begin
                cmd.rotate = 1'b1;
                state_next = ST_ARRIVE;
            end
            ST_ARRIVE:
            begin
                cmd.arrive = 1'b1;
                state_next = ST_TERM;
            end
            ST_TERM:
            begin
                cmd.term = 1'b1;
                if (status.term_take && status.nonempty)
                    state_next = ST_TAKE;
                else
                    state_next = ST_RESULT;
            end
            ST_TAKE:
            begin
                cmd.take   = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                cmd.result = 1'b1;
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

[rtl/rrps_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rrps_datapath
// Scheduler state: ready queue memory, current process, counters,
// configuration registers and the result register.
// ============================================================================
module rrps_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [rrps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rrps_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire rrps_pkg::req_t                     req_data,
    input  wire rrps_pkg::cmd_t                     cmd,
    output rrps_pkg::status_t                       status,
    input  wire logic                               result_ready,
    output logic                                    result_valid,
    output rrps_pkg::res_t                          result_data
);

    // configuration
    logic [rrps_pkg::SLICE_W-1:0]  slice_length_reg;
    logic [rrps_pkg::TICK_W-1:0]   tick_limit_reg;
    logic [rrps_pkg::QLIMIT_W-1:0] queue_limit_reg;

    // ready queue
    logic [rrps_pkg::ENTRY_W-1:0]  queue_mem [rrps_pkg::QUEUE_DEPTH];
    logic [rrps_pkg::ENTRY_W-1:0]  head_entry_reg;
    logic [rrps_pkg::QPTR_W-1:0]   head_reg;
    logic [rrps_pkg::QPTR_W-1:0]   tail_reg;
    logic [rrps_pkg::QCNT_W-1:0]   count_reg;

    // scheduler state
    logic [rrps_pkg::ID_WIDTH-1:0] cur_id_reg;
    logic [rrps_pkg::RUN_W-1:0]    cur_run_reg;
    logic                          cur_idle_reg;
    logic [rrps_pkg::ID_WIDTH-1:0] next_id_reg;
    logic [rrps_pkg::TICK_W-1:0]   tick_reg;
    logic [rrps_pkg::SLICE_W-1:0]  slice_reg;
    logic [rrps_pkg::TOTAL_W-1:0]  total_reg;
    logic                          done_reg;
    logic                          dropped_reg;
    rrps_pkg::req_t                req_reg;

    logic                          result_valid_reg;
    rrps_pkg::res_t                result_reg;

    // combinational helpers
    logic [rrps_pkg::SLICE_W-1:0]  slen;
    logic [rrps_pkg::SLICE_W:0]    slice_inc;
    logic                          slice_end;
    logic [rrps_pkg::LIM_W-1:0]    eff_limit;
    logic [rrps_pkg::LIM_W-1:0]    count_ext;
    logic                          queue_full;
    logic [rrps_pkg::QPTR_W-1:0]   head_adv;
    logic [rrps_pkg::QPTR_W-1:0]   tail_adv;
    logic [rrps_pkg::ID_WIDTH-1:0] id_inc;
    logic [rrps_pkg::TOTAL_W:0]    total_sum;
    logic                          out_free;
    logic                          done_now;
    logic                          wr_en;
    logic [rrps_pkg::QPTR_W-1:0]   wr_addr;
    logic [rrps_pkg::ENTRY_W-1:0]  wr_data;
    logic                          arrive_ok;

    assign slen      = (slice_length_reg == '0) ? rrps_pkg::SLICE_W'(1) : slice_length_reg;
    assign slice_inc = {1'b0, slice_reg} + (rrps_pkg::SLICE_W + 1)'(1);
    assign slice_end = (slice_inc >= {1'b0, slen});

    always_comb
    begin
        priority if (queue_limit_reg == '0)
            eff_limit = rrps_pkg::LIM_W'(1);
        else if (rrps_pkg::LIM_W'(queue_limit_reg) > rrps_pkg::LIM_W'(rrps_pkg::QUEUE_DEPTH))
            eff_limit = rrps_pkg::LIM_W'(rrps_pkg::QUEUE_DEPTH);
        else
            eff_limit = rrps_pkg::LIM_W'(queue_limit_reg);
    end

    assign count_ext  = rrps_pkg::LIM_W'(count_reg);
    assign queue_full = (count_ext >= eff_limit);
    assign arrive_ok  = req_reg.arrival && !queue_full;

    assign head_adv = (head_reg == rrps_pkg::QPTR_W'(rrps_pkg::QUEUE_DEPTH - 1))
                      ? '0 : head_reg + rrps_pkg::QPTR_W'(1);
    assign tail_adv = (tail_reg == rrps_pkg::QPTR_W'(rrps_pkg::QUEUE_DEPTH - 1))
                      ? '0 : tail_reg + rrps_pkg::QPTR_W'(1);

    // zero is the idle id, skipped on wrap
    assign id_inc = (next_id_reg == '1) ? rrps_pkg::ID_WIDTH'(1)
                                        : next_id_reg + rrps_pkg::ID_WIDTH'(1);

    assign total_sum = {1'b0, total_reg} + (rrps_pkg::TOTAL_W + 1)'(cur_run_reg);

    assign out_free = !result_valid_reg || result_ready;
    assign done_now = done_reg || (tick_reg >= tick_limit_reg);

    assign status.done      = done_reg;
    assign status.slice_end = slice_end;
    assign status.nonempty  = (count_reg != '0);
    assign status.term_take = req_reg.terminate && !cur_idle_reg;
    assign status.out_free  = out_free;

    // single queue write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = tail_reg;
        wr_data = {cur_id_reg, cur_run_reg};
        if (cmd.rotate && !cur_idle_reg)
            wr_en = 1'b1;
        else if (cmd.arrive && arrive_ok)
        begin
            wr_en   = 1'b1;
            wr_data = {next_id_reg, {rrps_pkg::RUN_W{1'b0}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            queue_mem[wr_addr] <= wr_data;
        head_entry_reg <= queue_mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_length_reg <= rrps_pkg::SLICE_LENGTH_RST;
            tick_limit_reg   <= rrps_pkg::TICK_LIMIT_RST;
            queue_limit_reg  <= rrps_pkg::QUEUE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rrps_pkg::CFG_SLICE_LENGTH:
                    slice_length_reg <= cfg_data[rrps_pkg::SLICE_W-1:0];
                rrps_pkg::CFG_TICK_LIMIT:
                    tick_limit_reg <= cfg_data[rrps_pkg::TICK_W-1:0];
                rrps_pkg::CFG_QUEUE_LIMIT:
                    queue_limit_reg <= cfg_data[rrps_pkg::QLIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            cur_id_reg   <= '0;
            cur_run_reg  <= '0;
            cur_idle_reg <= 1'b1;
            next_id_reg  <= rrps_pkg::ID_WIDTH'(1);
            tick_reg     <= '0;
            slice_reg    <= '0;
            total_reg    <= '0;
            done_reg     <= 1'b0;
            dropped_reg  <= 1'b0;
            req_reg      <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                req_reg     <= req_data;
                dropped_reg <= 1'b0;
            end

            if (cmd.count && !done_reg)
            begin
                tick_reg <= tick_reg + rrps_pkg::TICK_W'(1);
                if (!cur_idle_reg && cur_run_reg != '1)
                    cur_run_reg <= cur_run_reg + rrps_pkg::RUN_W'(1);
                slice_reg <= slice_end ? '0 : slice_inc[rrps_pkg::SLICE_W-1:0];
            end

            // slice end: head becomes current, old current goes to the tail
            if (cmd.rotate)
            begin
                cur_id_reg   <= head_entry_reg[rrps_pkg::ENTRY_W-1:rrps_pkg::RUN_W];
                cur_run_reg  <= head_entry_reg[rrps_pkg::RUN_W-1:0];
                cur_idle_reg <= 1'b0;
                head_reg     <= head_adv;
                if (!cur_idle_reg)
                    tail_reg <= tail_adv;
                else
                    count_reg <= count_reg - rrps_pkg::QCNT_W'(1);
            end

            if (cmd.arrive && req_reg.arrival)
            begin
                if (queue_full)
                    dropped_reg <= 1'b1;
                else
                begin
                    tail_reg    <= tail_adv;
                    count_reg   <= count_reg + rrps_pkg::QCNT_W'(1);
                    next_id_reg <= id_inc;
                end
            end

            if (cmd.term && req_reg.terminate && !cur_idle_reg)
            begin
                total_reg <= total_sum[rrps_pkg::TOTAL_W] ? '1
                                                          : total_sum[rrps_pkg::TOTAL_W-1:0];
                if (count_reg == '0)
                begin
                    cur_idle_reg <= 1'b1;
                    cur_id_reg   <= '0;
                    cur_run_reg  <= '0;
                end
            end

            if (cmd.take)
            begin
                cur_id_reg   <= head_entry_reg[rrps_pkg::ENTRY_W-1:rrps_pkg::RUN_W];
                cur_run_reg  <= head_entry_reg[rrps_pkg::RUN_W-1:0];
                cur_idle_reg <= 1'b0;
                head_reg     <= head_adv;
                count_reg    <= count_reg - rrps_pkg::QCNT_W'(1);
            end

            if (cmd.result && out_free)
                done_reg <= done_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (cmd.result && out_free)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result && out_free)
        begin
            result_reg.running_id      <= cur_idle_reg ? 16'd0 : 16'(cur_id_reg);
            result_reg.running_idle    <= cur_idle_reg;
            result_reg.total_run       <= total_reg;
            result_reg.arrival_dropped <= dropped_reg && !done_reg;
            result_reg.finished        <= done_now;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

endmodule
`default_nettype wire

[rtl/round_robin_process_scheduler.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// round_robin_process_scheduler
// Round-robin time-slice scheduler advanced one tick per request.
// ============================================================================
// Each request on req_* is one scheduler tick, optionally carrying a process
// arrival and a terminate of the running process; each tick returns exactly
// one result on result_* holding the running process, the saturating total
// run count of terminated processes, a dropped-arrival flag and the finished
// flag. A tick walks the count, arrival, terminate and result steps, adding
// a rotate step when a slice ends with a non-empty queue, a take step when
// a terminate takes the queue head; once the run has finished it goes from
// count straight to result. A result still waiting on result_ready stalls
// the sequence at its last step. Queue takes use the registered read of the
// ready-queue memory, which has a single write port. The queue memory needs
// no clearing pass after reset: only written entries are ever read.
// Configuration writes (cfg_we, cfg_index, cfg_data) are taken in any cycle
// and should only be issued while the block is idle.
// ============================================================================
module round_robin_process_scheduler (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    // configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [rrps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rrps_pkg::CFG_DATA_W-1:0] cfg_data,

    // tick request channel
    input  wire logic                            req_valid,
    output logic                                 req_ready,
    input  wire rrps_pkg::req_t                  req_data,

    // result channel
    output logic                                 result_valid,
    input  wire logic                            result_ready,
    output rrps_pkg::res_t                       result_data
);

    // command and status between sequencer and datapath
    rrps_pkg::cmd_t    cmd;
    rrps_pkg::status_t status;

    // sequencer: one step of the tick per cycle unless the result stalls
    rrps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // queue memory, counters and the result register
    rrps_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_data     (req_data),
        .cmd          (cmd),
        .status       (status),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result_data  (result_data)
    );

endmodule
`default_nettype wire

[rtl/rrps_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rrps_checker
// Port-level checks of the scheduler's result stream.
// ============================================================================
module rrps_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            result_valid,
    input wire logic                            result_ready,
    input wire rrps_pkg::res_t                  result_data
);

    logic                         seen_finished_reg;
    logic                         have_total_reg;
    logic [rrps_pkg::TOTAL_W-1:0] last_total_reg;
    logic                         res_take;

    assign res_take = result_valid && result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_finished_reg <= 1'b0;
            have_total_reg    <= 1'b0;
            last_total_reg    <= '0;
        end
        else if (res_take)
        begin
            if (result_data.finished)
                seen_finished_reg <= 1'b1;
            have_total_reg <= 1'b1;
            last_total_reg <= result_data.total_run;
        end
    end

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result changed while stalled");

    // finished is sticky and freezes the drop flag
    a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && seen_finished_reg |->
            result_data.finished && !result_data.arrival_dropped)
        else $error("result after finish not frozen");

    // terminated run total never goes down
    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && have_total_reg |-> result_data.total_run >= last_total_reg)
        else $error("total run decreased");

    // idle process always reports id zero
    a_idle_id: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.running_idle |-> result_data.running_id == 16'd0)
        else $error("idle with nonzero id");

endmodule

bind round_robin_process_scheduler rrps_checker u_checker (.*);
`default_nettype wire
